>>> hdl/dmsp_pkg.sv
`timescale 1ns / 1ps
// Package for the DNS message stream parser: parse phases, queue record type
// and reset constants. No dependencies; imported by every parser module.
package dmsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QLEN   = 3'd1,
    PH_QCHAR  = 3'd2,
    PH_QTAIL  = 3'd3,
    PH_ANSWER = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // One queued result, as decided by the front end
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_char;
    logic [15:0] msg_id;
    logic [15:0] flags;
    logic [15:0] qdcount;
    logic [15:0] ancount;
    logic [15:0] qtype;
    logic [31:0] ttl;
  } evt_t;

  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [15:0] REQ_QTYPE_RST  = 16'd28;
  localparam logic [7:0]  DOT_CHAR       = 8'h2E;
  localparam logic [3:0]  HDR_ID_LO      = 4'd3;
  localparam logic [3:0]  HDR_FLAGS_LO   = 4'd5;
  localparam logic [3:0]  HDR_QD_LO      = 4'd7;
  localparam logic [3:0]  HDR_AN_LO      = 4'd9;
  localparam logic [3:0]  HDR_LAST       = 4'd13;
  localparam logic [3:0]  HDR_FIRST      = 4'd2;
  localparam logic [3:0]  QT_TYPE_LO     = 4'd1;
  localparam logic [3:0]  QT_LAST        = 4'd3;
  localparam logic [3:0]  AN_TTL_FIRST   = 4'd6;
  localparam logic [3:0]  AN_LAST        = 4'd9;

endpackage

>>> hdl/dmsp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the DNS message stream parser.
// Depends on nothing; used by the front end, back end and top level.
interface dmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last_byte;

  modport source (output valid, output msg_byte, output last_byte, input ready);
  modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface

interface dmsp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_char;
  logic [15:0] msg_id;
  logic        is_response;
  logic [3:0]  opcode;
  logic [3:0]  aa_tc_rd_ra;
  logic [3:0]  rcode;
  logic [15:0] question_count;
  logic [15:0] answer_count;
  logic [15:0] question_type;
  logic [31:0] answer_ttl;
  logic        is_valid;

  modport source (
    output valid, output kind, output name_char, output msg_id, output is_response,
    output opcode, output aa_tc_rd_ra, output rcode, output question_count,
    output answer_count, output question_type, output answer_ttl, output is_valid,
    input ready
  );
  modport sink (
    input valid, input kind, input name_char, input msg_id, input is_response,
    input opcode, input aa_tc_rd_ra, input rcode, input question_count,
    input answer_count, input question_type, input answer_ttl, input is_valid,
    output ready
  );
endinterface

>>> hdl/dmsp_front.sv
`timescale 1ns / 1ps
// Front end: accepts message bytes, walks the parse phases, holds header and
// record fields and pushes result records. Depends on dmsp_pkg and dmsp_if.
module dmsp_front (
  input  logic             clk,
  input  logic             rst_n,
  dmsp_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output dmsp_pkg::evt_t   push_evt
);
  import dmsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  boff_r, boff_nxt;
  logic [7:0]  label_r, label_nxt;
  logic        first_r, first_nxt;
  logic [3:0]  fld_r, fld_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [15:0] qd_r, qd_nxt;
  logic [15:0] an_r, an_nxt;
  logic [15:0] qt_r, qt_nxt;
  logic [31:0] ttl_r, ttl_nxt;

  logic       acc;
  logic       last;
  logic [7:0] b;
  logic       emit_char;
  logic [7:0] ch;
  phase_t     after_q;

  assign in_ch.ready = !q_full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign b    = in_ch.msg_byte;
  assign last = in_ch.last_byte;
  assign after_q = (an_r != 16'd0) ? PH_ANSWER : PH_DONE;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (boff_r == HDR_LAST) begin
          phase_nxt = (qd_r != 16'd0) ? PH_QLEN : after_q;
        end
      end
      PH_QLEN:   phase_nxt = (b == 8'd0) ? PH_QTAIL : PH_QCHAR;
      PH_QCHAR:  phase_nxt = (label_r == 8'd1) ? PH_QLEN : PH_QCHAR;
      PH_QTAIL:  phase_nxt = (fld_r >= QT_LAST) ? after_q : PH_QTAIL;
      PH_ANSWER: phase_nxt = (fld_r >= AN_LAST) ? PH_DONE : PH_ANSWER;
      PH_DONE:   phase_nxt = PH_DONE;
      default:   phase_nxt = phase_r;
    endcase
  end

  // Field datapath
  always_comb begin
    boff_nxt  = boff_r;
    label_nxt = label_r;
    first_nxt = first_r;
    fld_nxt   = fld_r;
    asm_nxt   = asm_r;
    id_nxt    = id_r;
    flags_nxt = flags_r;
    qd_nxt    = qd_r;
    an_nxt    = an_r;
    qt_nxt    = qt_r;
    ttl_nxt   = ttl_r;
    case (phase_r)
      PH_HEADER: begin
        if (boff_r >= HDR_FIRST) begin
          asm_nxt = {8'd0, asm_r[7:0], b};
          if (boff_r == HDR_ID_LO)    id_nxt    = {asm_r[7:0], b};
          if (boff_r == HDR_FLAGS_LO) flags_nxt = {asm_r[7:0], b};
          if (boff_r == HDR_QD_LO)    qd_nxt    = {asm_r[7:0], b};
          if (boff_r == HDR_AN_LO)    an_nxt    = {asm_r[7:0], b};
        end
        if (boff_r == HDR_LAST) begin
          asm_nxt = '0;
          fld_nxt = '0;
        end
        boff_nxt = boff_r + 4'd1;
      end
      PH_QLEN: begin
        if (b == 8'd0) begin
          fld_nxt = '0;
          asm_nxt = '0;
        end else begin
          first_nxt = 1'b1;
          label_nxt = b;
        end
      end
      PH_QCHAR: label_nxt = label_r - 8'd1;
      PH_QTAIL: begin
        asm_nxt = {8'd0, asm_r[7:0], b};
        if (fld_r == QT_TYPE_LO) qt_nxt = {asm_r[7:0], b};
        if (fld_r >= QT_LAST) begin
          fld_nxt = '0;
          asm_nxt = '0;
        end else begin
          fld_nxt = fld_r + 4'd1;
        end
      end
      PH_ANSWER: begin
        if (fld_r >= AN_TTL_FIRST) asm_nxt = {asm_r[15:0], b};
        if (fld_r >= AN_LAST) begin
          ttl_nxt = {asm_r, b};
          asm_nxt = '0;
          fld_nxt = '0;
        end else begin
          fld_nxt = fld_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // Outputs: name characters and result records
  always_comb begin
    emit_char = 1'b0;
    ch        = 8'd0;
    unique case (phase_r)
      PH_QLEN: begin
        emit_char = (b != 8'd0) && first_r;
        ch        = DOT_CHAR;
      end
      PH_QCHAR: begin
        emit_char = 1'b1;
        ch        = b;
      end
      default: ;
    endcase
  end

  always_comb begin
    push_evt = '0;
    push     = acc && (last || emit_char);
    if (last) begin
      push_evt.kind    = KIND_SUMMARY;
      push_evt.msg_id  = id_nxt;
      push_evt.flags   = flags_nxt;
      push_evt.qdcount = qd_nxt;
      push_evt.ancount = an_nxt;
      push_evt.qtype   = qt_nxt;
      push_evt.ttl     = ttl_nxt;
    end else begin
      push_evt.kind      = KIND_CHAR;
      push_evt.name_char = ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last)) begin
      phase_r <= PH_HEADER;
      boff_r  <= '0;
      label_r <= '0;
      first_r <= 1'b0;
      fld_r   <= '0;
      asm_r   <= '0;
      id_r    <= '0;
      flags_r <= '0;
      qd_r    <= '0;
      an_r    <= '0;
      qt_r    <= '0;
      ttl_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      boff_r  <= boff_nxt;
      label_r <= label_nxt;
      first_r <= first_nxt;
      fld_r   <= fld_nxt;
      asm_r   <= asm_nxt;
      id_r    <= id_nxt;
      flags_r <= flags_nxt;
      qd_r    <= qd_nxt;
      an_r    <= an_nxt;
      qt_r    <= qt_nxt;
      ttl_r   <= ttl_nxt;
    end
  end

  a_qchar_label: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_QCHAR) |-> (label_r != 8'd0))
    else $error("name character phase with no label bytes left");
  a_header_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (boff_r <= HDR_LAST))
    else $error("header offset past header end");

endmodule

>>> hdl/dmsp_fifo.sv
`timescale 1ns / 1ps
// Short record queue between front and back end of the parser.
// Depends on dmsp_pkg for the record type.
module dmsp_fifo #(
  parameter int unsigned DEPTH = dmsp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dmsp_pkg::evt_t push_evt,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output dmsp_pkg::evt_t head_evt
);
  import dmsp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  evt_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_evt  = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("record dropped: queue full");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count lost a push");

endmodule

>>> hdl/dmsp_back.sv
`timescale 1ns / 1ps
// Back end: pops queued records, unpacks flags, decides validity and holds
// the result in the output register. Depends on dmsp_pkg and dmsp_if.
module dmsp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  dmsp_pkg::evt_t head_evt,
  input  logic [15:0]    req_qtype,
  output logic           pop,
  dmsp_out_if.source     out_ch
);
  import dmsp_pkg::*;

  logic        valid_r;
  logic        kind_r;
  logic [7:0]  char_r;
  logic [15:0] id_r;
  logic        resp_r;
  logic [3:0]  opcode_r;
  logic [3:0]  flg_r;
  logic [3:0]  rcode_r;
  logic [15:0] qd_r;
  logic [15:0] an_r;
  logic [15:0] qt_r;
  logic [31:0] ttl_r;
  logic        ok_r, ok_nxt;

  assign pop = q_not_empty && (!valid_r || out_ch.ready);

  // Summary is valid unless a question type is present and mismatches, or a
  // response carries no answers; character records always carry zero here.
  always_comb begin
    ok_nxt = 1'b0;
    if (head_evt.kind == KIND_SUMMARY) begin
      if ((head_evt.qdcount != 16'd0) && (head_evt.qtype != req_qtype)) ok_nxt = 1'b0;
      else if (!head_evt.flags[15]) ok_nxt = 1'b1;
      else ok_nxt = (head_evt.ancount != 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= head_evt.kind;
      char_r   <= head_evt.name_char;
      id_r     <= head_evt.msg_id;
      resp_r   <= head_evt.flags[15];
      opcode_r <= head_evt.flags[14:11];
      flg_r    <= head_evt.flags[10:7];
      rcode_r  <= head_evt.flags[3:0];
      qd_r     <= head_evt.qdcount;
      an_r     <= head_evt.ancount;
      qt_r     <= head_evt.qtype;
      ttl_r    <= head_evt.ttl;
      ok_r     <= ok_nxt;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.name_char      = char_r;
  assign out_ch.msg_id         = id_r;
  assign out_ch.is_response    = resp_r;
  assign out_ch.opcode         = opcode_r;
  assign out_ch.aa_tc_rd_ra    = flg_r;
  assign out_ch.rcode          = rcode_r;
  assign out_ch.question_count = qd_r;
  assign out_ch.answer_count   = an_r;
  assign out_ch.question_type  = qt_r;
  assign out_ch.answer_ttl     = ttl_r;
  assign out_ch.is_valid       = ok_r;

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped record not presented");
  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == KIND_CHAR)) |-> (!ok_r && (id_r == 16'd0)))
    else $error("character result carries summary fields");

endmodule

>>> hdl/dns_message_stream_parser.sv
`timescale 1ns / 1ps
// Top level of the DNS message stream parser: front end, record queue, back end.
// Each result passes from the record queue into the back-end output register.
// One byte per cycle unless the queue is full; one result per cycle when out_ch.ready.
// in_ch.ready drops only when the record queue is full, i.e. after output stalls.
// Reset (rst_n low, synchronous) clears parse state, queue and output valid;
// required_qtype returns to 28. Each last byte also returns parsing to its reset state.
module dns_message_stream_parser #(
  parameter int unsigned QUEUE_DEPTH = dmsp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  dmsp_in_if.sink     in_ch,
  dmsp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import dmsp_pkg::*;

  logic [15:0] req_qtype_r;
  logic        push;
  evt_t        push_evt;
  logic        pop;
  logic        q_full;
  logic        q_not_empty;
  evt_t        head_evt;

  // Required question type; the user must write it only while the parser is idle (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_qtype_r <= REQ_QTYPE_RST;
    end else if (cfg_we) begin
      req_qtype_r <= cfg_data;
    end
  end

  // Front end: take one byte per transfer, track phase, push a record for each
  // name character and for the summary on the last byte.
  dmsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_evt (push_evt)
  );

  // Decouple the two sides so an output stall does not stall the byte stream
  // until the queue fills.
  dmsp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_evt  (push_evt),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_evt  (head_evt)
  );

  // Back end: unpack flags, judge validity, hold the result until its transfer.
  dmsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head_evt    (head_evt),
    .req_qtype   (req_qtype_r),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

>>> tb/dns_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the DNS message stream parser: replays the parse of every byte
// transfer and compares each result transfer. Depends on dmsp_pkg and dmsp_if.
module dns_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  dmsp_in_if          in_ch,
  dmsp_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_checked
);
  import dmsp_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_char;
    logic [15:0] msg_id;
    logic        is_response;
    logic [3:0]  opcode;
    logic [3:0]  aa_tc_rd_ra;
    logic [3:0]  rcode;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] question_type;
    logic [31:0] answer_ttl;
    logic        is_valid;
  } dns_result_t;

  // Mirror of the parser state
  logic [15:0] want_qtype = REQ_QTYPE_RST;
  logic [15:0] hdr_pos;
  phase_t      phase;
  logic [7:0]  label_left;
  logic        label_seen;
  logic [3:0]  fld_pos;
  logic [31:0] word;
  logic [15:0] id_q, flags_q, qd_q, an_q, qtype_q;
  logic [31:0] ttl_q;

  dns_result_t expected_results[$];
  int unsigned bad_count = 0;
  int unsigned seen_count = 0;
  bit          field_wrong;

  task automatic clear_message();
    hdr_pos = '0;
    phase = PH_HEADER;
    label_left = '0;
    label_seen = 1'b0;
    fld_pos = '0;
    word = '0;
    id_q = '0;
    flags_q = '0;
    qd_q = '0;
    an_q = '0;
    qtype_q = '0;
    ttl_q = '0;
  endtask

  task automatic leave_question();
    fld_pos = '0;
    word = '0;
    phase = (an_q != 0) ? PH_ANSWER : PH_DONE;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    dns_result_t r;
    bit          emit;
    logic [7:0]  ch;
    emit = 1'b0;
    ch = '0;
    r = '0;
    case (phase)
      PH_HEADER: begin
        if (hdr_pos >= HDR_FIRST && hdr_pos <= HDR_LAST) begin
          word = {16'h0, word[7:0], b};
          if (hdr_pos == HDR_ID_LO) id_q = word[15:0];
          if (hdr_pos == HDR_FLAGS_LO) flags_q = word[15:0];
          if (hdr_pos == HDR_QD_LO) qd_q = word[15:0];
          if (hdr_pos == HDR_AN_LO) an_q = word[15:0];
        end
        if (hdr_pos == HDR_LAST) begin
          word = '0;
          fld_pos = '0;
          if (qd_q != 0) phase = PH_QLEN;
          else leave_question();
        end
        if (hdr_pos != 16'hFFFF) hdr_pos++;
      end
      PH_QLEN: begin
        if (b == 0) begin
          phase = PH_QTAIL;
          fld_pos = '0;
          word = '0;
        end else begin
          if (label_seen) begin
            emit = 1'b1;
            ch = DOT_CHAR;
          end
          label_seen = 1'b1;
          label_left = b;
          phase = PH_QCHAR;
        end
      end
      PH_QCHAR: begin
        emit = 1'b1;
        ch = b;
        label_left--;
        if (label_left == 0) phase = PH_QLEN;
      end
      PH_QTAIL: begin
        word = {16'h0, word[7:0], b};
        if (fld_pos == QT_TYPE_LO) qtype_q = word[15:0];
        if (fld_pos >= QT_LAST) leave_question();
        else fld_pos++;
      end
      PH_ANSWER: begin
        if (fld_pos >= AN_TTL_FIRST) word = {word[23:0], b};
        if (fld_pos >= AN_LAST) begin
          ttl_q = word;
          word = '0;
          fld_pos = '0;
          phase = PH_DONE;
        end else begin
          fld_pos++;
        end
      end
      default: ;
    endcase

    if (lst) begin
      r.kind = KIND_SUMMARY;
      r.msg_id = id_q;
      r.is_response = flags_q[15];
      r.opcode = flags_q[14:11];
      r.aa_tc_rd_ra = flags_q[10:7];
      r.rcode = flags_q[3:0];
      r.question_count = qd_q;
      r.answer_count = an_q;
      r.question_type = qtype_q;
      r.answer_ttl = ttl_q;
      if (qd_q != 0 && qtype_q != want_qtype) r.is_valid = 1'b0;
      else if (!flags_q[15]) r.is_valid = 1'b1;
      else r.is_valid = (an_q != 0);
      expected_results.push_back(r);
      clear_message();
    end else if (emit) begin
      r.kind = KIND_CHAR;
      r.name_char = ch;
      expected_results.push_back(r);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want, got);
    if (got !== want) begin
      field_wrong = 1'b1;
      if (bad_count < 10)
        $display("%0t: result %0d, %s expected 0x%0h, got 0x%0h",
                 $time, seen_count, fname, want, got);
    end
  endtask

  task automatic check_result();
    dns_result_t want;
    if (expected_results.size() == 0) begin
      if (bad_count < 10)
        $display("%0t: result with nothing expected, kind %0d char 0x%0h",
                 $time, out_ch.kind, out_ch.name_char);
      bad_count++;
      return;
    end
    want = expected_results.pop_front();
    field_wrong = 1'b0;
    check_field("kind", want.kind, out_ch.kind);
    check_field("name_char", want.name_char, out_ch.name_char);
    check_field("msg_id", want.msg_id, out_ch.msg_id);
    check_field("is_response", want.is_response, out_ch.is_response);
    check_field("opcode", want.opcode, out_ch.opcode);
    check_field("aa_tc_rd_ra", want.aa_tc_rd_ra, out_ch.aa_tc_rd_ra);
    check_field("rcode", want.rcode, out_ch.rcode);
    check_field("question_count", want.question_count, out_ch.question_count);
    check_field("answer_count", want.answer_count, out_ch.answer_count);
    check_field("question_type", want.question_type, out_ch.question_type);
    check_field("answer_ttl", want.answer_ttl, out_ch.answer_ttl);
    check_field("is_valid", want.is_valid, out_ch.is_valid);
    if (field_wrong) bad_count++;
    seen_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_qtype = REQ_QTYPE_RST;
      clear_message();
      expected_results.delete();
    end else begin
      if (cfg_we) want_qtype = cfg_data;
      // A result never comes from the byte of the same edge, so order is free here
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.msg_byte, in_ch.last_byte);
    end
    mismatches <= bad_count;
    outstanding <= expected_results.size();
    results_checked <= seen_count;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the DNS message stream parser bench: clock, reset, byte traffic, receiver
// stalls and the verdict. Depends on dmsp_pkg, dmsp_if and dns_result_checker.
module tb_top;
  import dmsp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;

  // Handshake pressure, set per phase by the stimulus process
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  int unsigned bytes_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned phase_bytes = 0;
  logic [15:0] current_qtype = REQ_QTYPE_RST;
  logic [7:0]  msg_bytes[$];

  // Phase table: sender idle percent, receiver stall percent, qtype written
  int          send_idle[5]   = '{0, 46, 0, 12, 0};
  int          recv_stall[5]  = '{0, 0, 46, 12, 0};
  logic [15:0] phase_qtype[5] = '{16'd0, 16'hFFFF, 16'h0000, 16'd0, 16'd28};

  dmsp_in_if  in_ch ();
  dmsp_out_if out_ch ();

  dns_message_stream_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  dns_result_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls at the phase rate, or a long hold-off when requested.
  // The hold-off is counted here so the sender keeps offering bytes meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push16(input logic [15:0] v);
    msg_bytes.push_back(v[15:8]);
    msg_bytes.push_back(v[7:0]);
  endtask

  // Offer one byte, idling first at the phase rate; return on its transfer edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.msg_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    phase_bytes++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    messages_sent++;
  endtask

  // Drop valid and hold until every expected result has been taken
  task automatic wait_drained(input int limit);
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Register write only with the parser idle; leave room for in-flight bytes
  task automatic write_qtype(input logic [15:0] v);
    wait_drained(100000);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    current_qtype = v;
  endtask

  // Length prefix, header, first question, first answer, then some trailing bytes
  task automatic make_wellformed();
    logic [15:0] qd, an, qtype;
    int          sel, nlabels, len;
    sel = $urandom_range(99);
    qd = (sel < 70) ? 16'd1 : (sel < 85) ? 16'd0 : 16'($urandom);
    sel = $urandom_range(99);
    an = (sel < 40) ? 16'd1 : (sel < 70) ? 16'd0 : 16'($urandom);
    push16(16'($urandom));
    push16(16'($urandom));
    push16(16'($urandom));
    push16(qd);
    push16(an);
    push16(16'($urandom));
    push16(16'($urandom));
    if (qd != 0) begin
      nlabels = $urandom_range(0, 3);
      repeat (nlabels) begin
        len = ($urandom_range(59) == 0) ? $urandom_range(64, 255) : $urandom_range(1, 6);
        msg_bytes.push_back(8'(len));
        repeat (len) begin
          if ($urandom_range(3) == 0) msg_bytes.push_back(8'($urandom_range(255)));
          else msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
      end
      msg_bytes.push_back(8'h00);
      sel = $urandom_range(99);
      qtype = (sel < 50) ? current_qtype : (sel < 60) ? 16'h0000 :
              (sel < 70) ? 16'hFFFF : 16'($urandom);
      push16(qtype);
      push16(16'($urandom));
    end
    if (an != 0) begin
      push16(($urandom_range(3) != 0) ? 16'hC00C : 16'($urandom));
      push16(16'($urandom));
      push16(16'($urandom));
      push16(16'($urandom));
      push16(16'($urandom));
      push16(16'($urandom_range(0, 16)));
    end
    repeat ($urandom_range(0, 5)) msg_bytes.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    int  sel, keep;
    bit  paused;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.msg_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 5; p++) begin
      idle_pct = send_idle[p];
      stall_pct = recv_stall[p];
      // The first phase runs on the reset value of the qtype register
      if (p == 3) write_qtype(16'($urandom));
      else if (p != 0) write_qtype(phase_qtype[p]);
      phase_bytes = 0;
      paused = 1'b0;

      if (p == 0) begin
        // Single-byte message: summary with every field still zero
        msg_bytes = '{8'hFF};
        send_message();
        // Header only, all-ones id and flags, no questions, no answers
        msg_bytes = '{8'h00, 8'h0C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_message();
        // Ends with ANCOUNT half assembled: it must read as zero
        msg_bytes = '{8'h00, 8'h00, 8'h12, 8'h34, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00};
        send_message();
        // Stall the output for a long stretch while bytes keep coming
        hold_req = 60;
      end

      while (phase_bytes < 380) begin
        sel = $urandom_range(99);
        msg_bytes.delete();
        if (sel < 10) begin
          // Noise: a run of random bytes ending in a last marker
          repeat ($urandom_range(1, 30)) msg_bytes.push_back(8'($urandom_range(255)));
        end else begin
          make_wellformed();
          // Cut some messages short anywhere, inside the name too
          if (sel < 28) begin
            keep = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
          end
        end
        send_message();
        // Halfway through, pause the sender until all results are out
        if (!paused && phase_bytes >= 190) begin
          wait_drained(100000);
          paused = 1'b1;
        end
      end
    end

    wait_drained(5000);
    repeat (20) @(posedge clk);
    $display("Run covered %0d bytes in %0d messages, %0d results checked,",
             bytes_sent, messages_sent, results_checked);
    $display("over five handshake settings and four written qtype values.");
    if (outstanding != 0)
      $display("%0d expected results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
